// File: src/idhsr_pkg.sv
// Shared types, constants and helpers for the id value and hex sweep replace block.
package idhsr_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ID_W     = 64;
    localparam int unsigned TEXT_W   = 128;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned OUT_DEPTH = 8;
    localparam int unsigned MAX_RES  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_ID  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_ID = CFG_IDX_W'(1);

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_RAW  = 2'd1;
    localparam logic [1:0] KIND_TEXT = 2'd2;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [1:0]        kind;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_result;

    function automatic logic [TEXT_W-1:0] hex_text(input logic [ID_W-1:0] v);
        logic [TEXT_W-1:0] t;
        t = '0;
        for (int c = 0; c < 16; c++) begin
            t[TEXT_W-1-8*c -: 8] = HEX_DIGITS[v[ID_W-1-4*c -: 4]];
        end
        return t;
    endfunction

endpackage

// File: src/id_value_and_hex_sweep_replace_core.sv
// Top level: sliding four-word search and replace over a memory word stream.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one memory word per beat,
//   with i_is_final marking the last word of a sweep. Output channel
//   (o_out_valid / i_out_stall) returns each word in order with its match
//   kind, the running saturating replacement count and an end flag.
//   Registers search_id (index 0) and replace_id (index 1) are written on the
//   config channel; o_cfg_ready is always high. Their hex text is built at
//   write time.
//   The first three words of a sweep only fill the window; from the fourth on,
//   each input word yields one output word, checked and written into an
//   eight-entry output queue in the accept cycle, visible in the next cycle.
//   A final word yields up to four output words, drained one per unstalled cycle.
//   Throughput is one word per cycle; the input stalls while the output queue
//   holds more than four words, so a long output stall backs up the input
//   after at most eight queued words.
//   Reset clears window, fill level, count, queue pointers and both registers.
module id_value_and_hex_sweep_replace_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [idhsr_pkg::WORD_W-1:0]        i_mem_word,
    input  logic                                i_is_final,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [idhsr_pkg::WORD_W-1:0]        o_out_word,
    output logic [1:0]                          o_match_kind,
    output logic [idhsr_pkg::CNT_W-1:0]         o_hit_count,
    output logic                                o_is_end,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [idhsr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [idhsr_pkg::ID_W-1:0]          i_cfg_data
);

    localparam int unsigned PTR_W = $clog2(idhsr_pkg::OUT_DEPTH);
    localparam int unsigned CNT_QW = $clog2(idhsr_pkg::OUT_DEPTH + 1);
    localparam int unsigned WORD_W = idhsr_pkg::WORD_W;

    logic [idhsr_pkg::ID_W-1:0]    r_search;
    logic [idhsr_pkg::ID_W-1:0]    r_replace;
    logic [idhsr_pkg::TEXT_W-1:0]  r_search_txt;
    logic [idhsr_pkg::TEXT_W-1:0]  r_replace_txt;

    logic [WORD_W-1:0]             r_win [3];
    logic [WORD_W-1:0]             n_win [3];
    logic [1:0]                    r_fill;
    logic [1:0]                    n_fill;
    logic [idhsr_pkg::CNT_W-1:0]   r_total;
    logic [idhsr_pkg::CNT_W-1:0]   n_total;

    idhsr_pkg::t_result            r_queue [idhsr_pkg::OUT_DEPTH];
    logic [PTR_W-1:0]              r_wr_ptr;
    logic [PTR_W-1:0]              r_rd_ptr;
    logic [CNT_QW-1:0]             r_count;
    logic [CNT_QW-1:0]             n_count;

    logic                          accept;
    logic                          pop;
    logic [2:0]                    push;
    logic [2:0]                    res_n;
    idhsr_pkg::t_result            res [idhsr_pkg::MAX_RES];
    logic [WORD_W-1:0]             seq [4];
    logic [WORD_W-1:0]             w   [4];
    logic [1:0]                    kind;
    logic                          raw_hit;
    logic                          txt_hit;
    logic [idhsr_pkg::CNT_W-1:0]   tot_new;
    logic [PTR_W-1:0]              slot_off [idhsr_pkg::OUT_DEPTH];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_count > CNT_QW'(idhsr_pkg::OUT_DEPTH - idhsr_pkg::MAX_RES);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_count != '0;
    assign pop         = o_out_valid && !i_out_stall;
    assign push        = accept ? res_n : 3'd0;
    assign n_count     = r_count + CNT_QW'(push) - CNT_QW'(pop);

    assign o_out_word   = r_queue[r_rd_ptr].word;
    assign o_match_kind = r_queue[r_rd_ptr].kind;
    assign o_hit_count  = r_queue[r_rd_ptr].count;
    assign o_is_end     = r_queue[r_rd_ptr].last;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            seq[j] = (j < 3 && 2'(j) < r_fill) ? r_win[j % 3] : i_mem_word;
        end

        raw_hit = r_win[0] == r_search[63:32] && r_win[1] == r_search[31:0];
        txt_hit = r_win[0] == r_search_txt[127:96] && r_win[1] == r_search_txt[95:64]
               && r_win[2] == r_search_txt[63:32] && i_mem_word == r_search_txt[31:0];

        w[0] = r_win[0];
        w[1] = r_win[1];
        w[2] = r_win[2];
        w[3] = i_mem_word;
        kind = idhsr_pkg::KIND_NONE;
        priority if (raw_hit) begin
            w[0] = r_replace[63:32];
            w[1] = r_replace[31:0];
            kind = idhsr_pkg::KIND_RAW;
        end else if (txt_hit) begin
            w[0] = r_replace_txt[127:96];
            w[1] = r_replace_txt[95:64];
            w[2] = r_replace_txt[63:32];
            w[3] = r_replace_txt[31:0];
            kind = idhsr_pkg::KIND_TEXT;
        end
        tot_new = (kind != idhsr_pkg::KIND_NONE && r_total != '1) ? r_total + 1'b1 : r_total;

        for (int j = 0; j < 4; j++) begin
            res[j] = '{word: seq[j], kind: idhsr_pkg::KIND_NONE, count: r_total,
                       last: 2'(j) == r_fill};
        end
        n_win   = r_win;
        n_fill  = r_fill;
        n_total = r_total;
        res_n   = 3'd0;

        if (r_fill == 2'd3) begin
            res[0] = '{word: w[0], kind: kind, count: tot_new, last: 1'b0};
            for (int j = 1; j < 4; j++) begin
                res[j] = '{word: w[j], kind: idhsr_pkg::KIND_NONE, count: tot_new,
                           last: j == 3};
            end
            if (i_is_final) begin
                res_n   = 3'd4;
                n_total = '0;
                n_fill  = 2'd0;
            end else begin
                res_n    = 3'd1;
                n_total  = tot_new;
                n_win[0] = w[1];
                n_win[1] = w[2];
                n_win[2] = w[3];
            end
        end else if (i_is_final) begin
            res_n   = 3'(r_fill) + 3'd1;
            n_total = '0;
            n_fill  = 2'd0;
        end else begin
            n_win[r_fill] = i_mem_word;
            n_fill        = r_fill + 2'd1;
        end

        for (int e = 0; e < idhsr_pkg::OUT_DEPTH; e++) begin
            slot_off[e] = PTR_W'(e) - r_wr_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search      <= '0;
            r_replace     <= '0;
            r_search_txt  <= idhsr_pkg::hex_text('0);
            r_replace_txt <= idhsr_pkg::hex_text('0);
            r_fill        <= 2'd0;
            r_total       <= '0;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
            for (int j = 0; j < 3; j++) begin
                r_win[j] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == idhsr_pkg::REG_SEARCH_ID) begin
                    r_search     <= i_cfg_data;
                    r_search_txt <= idhsr_pkg::hex_text(i_cfg_data);
                end else if (i_cfg_index == idhsr_pkg::REG_REPLACE_ID) begin
                    r_replace     <= i_cfg_data;
                    r_replace_txt <= idhsr_pkg::hex_text(i_cfg_data);
                end
            end
            if (accept) begin
                r_win   <= n_win;
                r_fill  <= n_fill;
                r_total <= n_total;
            end
            r_wr_ptr <= r_wr_ptr + PTR_W'(push);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < idhsr_pkg::OUT_DEPTH; e++) begin
            if ({1'b0, slot_off[e]} < (PTR_W + 1)'(push)) begin
                r_queue[e] <= res[slot_off[e][1:0]];
            end
        end
    end

endmodule
